FILE: sv/rtac_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the region table access checker.
package rtac_pkg;

    localparam int REGIONS = 16;
    localparam int IDX_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CNT_W   = $clog2(REGIONS + 1);

    localparam int CMD_W   = 3;
    localparam int ADDR_W  = 64;
    localparam int SIZE_W  = 2;
    localparam int PERM_W  = 3;
    localparam int ST_W    = 3;
    localparam int RIDX_W  = 4;

    localparam logic [CMD_W-1:0] CMD_MAP      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_VALIDATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FETCH    = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
    localparam logic [ST_W-1:0] ST_FAULT    = 3'd4;

    localparam logic [PERM_W-1:0] PERM_READ  = 3'b001;
    localparam logic [PERM_W-1:0] PERM_WRITE = 3'b010;
    localparam logic [PERM_W-1:0] PERM_EXEC  = 3'b100;

    localparam logic [ADDR_W-1:0] FETCH_BYTES = 64'd4;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] length;
        logic [PERM_W-1:0] perms;
    } entry_t;

    typedef struct packed {
        logic              is_map;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        logic [PERM_W-1:0] need;
    } ctx_t;

    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] offset;
    } match_t;

endpackage

FILE: sv/rtac_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces.
interface rtac_req_if;
    logic                         valid;
    logic                         ready;
    logic [rtac_pkg::CMD_W-1:0]   command;
    logic [rtac_pkg::ADDR_W-1:0]  address;
    logic [rtac_pkg::ADDR_W-1:0]  length;
    logic [rtac_pkg::SIZE_W-1:0]  size_code;
    logic [rtac_pkg::PERM_W-1:0]  perms;

    modport source (output valid, command, address, length, size_code, perms, input ready);
    modport sink (input valid, command, address, length, size_code, perms, output ready);
endinterface

interface rtac_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [rtac_pkg::ST_W-1:0]    status;
    logic [rtac_pkg::RIDX_W-1:0]  region_index;
    logic [rtac_pkg::ADDR_W-1:0]  offset;

    modport source (output valid, status, region_index, offset, input ready);
    modport sink (input valid, status, region_index, offset, output ready);
endinterface

FILE: sv/rtac_table.sv
`timescale 1ns / 1ps
// Region table memory: one write port, one read port with registered data.
module rtac_table (
    input  logic                     clk,
    input  logic                     we,
    input  logic [rtac_pkg::IDX_W-1:0] waddr,
    input  rtac_pkg::entry_t         wdata,
    input  logic                     re,
    input  logic [rtac_pkg::IDX_W-1:0] raddr,
    output rtac_pkg::entry_t         rdata
);
    import rtac_pkg::*;

    entry_t mem [REGIONS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/rtac_match.sv
`timescale 1ns / 1ps
// Two-stage compare pipeline: overlap test for map, containment test for accesses.
module rtac_match (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       vld,
    input  logic                       flush,
    input  rtac_pkg::entry_t           ent,
    input  logic [rtac_pkg::IDX_W-1:0] idx,
    input  rtac_pkg::ctx_t             ctx,
    output rtac_pkg::match_t           res
);
    import rtac_pkg::*;

    logic              v2_reg;
    logic              ok_reg;
    logic [ADDR_W-1:0] d_reg;
    logic [ADDR_W-1:0] lim_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              ok_next;
    logic [ADDR_W-1:0] d_next;
    logic [ADDR_W-1:0] lim_next;
    logic              ge;
    logic [ADDR_W:0]   end_sum;
    logic              hit;

    // stage 1: one wide subtract per entry
    always_comb
    begin
        ge = (ent.base >= ctx.addr);
        if (ctx.is_map)
        begin
            d_next   = ge ? (ent.base - ctx.addr) : (ctx.addr - ent.base);
            lim_next = ge ? ctx.len : ent.length;
            ok_next  = 1'b1;
        end
        else
        begin
            d_next   = ctx.addr - ent.base;
            lim_next = ent.length;
            ok_next  = ((ent.perms & ctx.need) == ctx.need) && (ent.base <= ctx.addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= vld && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld)
        begin
            ok_reg  <= ok_next;
            d_reg   <= d_next;
            lim_reg <= lim_next;
            idx_reg <= idx;
        end
    end

    // stage 2: map overlap; access end (offset + length, 65 bits) within region
    always_comb
    begin
        end_sum = {1'b0, d_reg} + {1'b0, ctx.len};
        if (ctx.is_map)
        begin
            hit = ok_reg && (d_reg < lim_reg);
        end
        else
        begin
            hit = ok_reg && (end_sum <= {1'b0, lim_reg});
        end
    end

    assign res.valid  = v2_reg;
    assign res.hit    = hit;
    assign res.idx    = idx_reg;
    assign res.offset = d_reg;

endmodule

FILE: sv/region_table_access_checker_core.sv
`timescale 1ns / 1ps
// Region table access checker: top level with command sequencer and response register.
//
//   channel | role | fields
//   --------+------+------------------------------------------------
//   req     | sink | command, address, length, size_code, perms
//   rsp     | src  | status, region_index, offset
//
// One command at a time: accept, a check state, then a table scan that reads one
// entry per cycle from the region memory through the compare pipeline, ending early
// on a hit, then the done state loads the response register once it is free.
// Early rejects go from the check state straight to the done state and skip the scan.
// Reset clears the region count; the table memory is not cleared.
// The next word is accepted while a response still waits for rsp.ready.
module region_table_access_checker_core (
    input  logic       clk,
    input  logic       rst_n,
    rtac_req_if.sink   req,
    rtac_rsp_if.source rsp
);
    import rtac_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [PERM_W-1:0] perms_reg, perms_next;
    logic [ADDR_W-1:0] acc_len_reg, acc_len_next;
    logic [PERM_W-1:0] need_reg, need_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic [ADDR_W-1:0] res_off_reg, res_off_next;
    logic              out_vld_reg, out_vld_next;
    logic [ST_W-1:0]   out_st_reg, out_st_next;
    logic [RIDX_W-1:0] out_idx_reg, out_idx_next;
    logic [ADDR_W-1:0] out_off_reg, out_off_next;

    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    entry_t            wdata;
    entry_t            rdata;
    ctx_t              ctx;
    match_t            mres;
    logic              flush;
    logic              is_map;

    assign is_map = (cmd_reg == CMD_MAP);

    assign ctx.is_map = is_map;
    assign ctx.addr   = addr_reg;
    assign ctx.len    = acc_len_reg;
    assign ctx.need   = need_reg;

    assign wdata.base   = addr_reg;
    assign wdata.length = len_reg;
    assign wdata.perms  = perms_reg;

    rtac_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    rtac_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .vld   (rd_vld_reg),
        .flush (flush),
        .ent   (rdata),
        .idx   (rd_idx_reg),
        .ctx   (ctx),
        .res   (mres)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_vld_reg;
    assign rsp.status       = out_st_reg;
    assign rsp.region_index = out_idx_reg;
    assign rsp.offset       = out_off_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        len_next     = len_reg;
        size_next    = size_reg;
        perms_next   = perms_reg;
        acc_len_next = acc_len_reg;
        need_next    = need_reg;
        count_next   = count_reg;
        iss_next     = iss_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        st_next      = st_reg;
        res_idx_next = res_idx_reg;
        res_off_next = res_off_reg;
        out_vld_next = out_vld_reg && !rsp.ready;
        out_st_next  = out_st_reg;
        out_idx_next = out_idx_reg;
        out_off_next = out_off_reg;
        re           = 1'b0;
        raddr        = iss_reg[IDX_W-1:0];
        we           = 1'b0;
        flush        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    addr_next  = req.address;
                    len_next   = req.length;
                    size_next  = req.size_code;
                    perms_next = req.perms;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                st_next      = ST_OK;
                res_idx_next = '0;
                res_off_next = '0;
                iss_next     = '0;
                acc_len_next = len_reg;
                need_next    = perms_reg;
                state_next   = S_SCAN;
                unique case (cmd_reg)
                    CMD_MAP:
                    begin
                        if (len_reg == '0 || perms_reg == '0)
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_DONE;
                        end
                        else if ((len_reg - 64'd1) > ~addr_reg)
                        begin
                            st_next    = ST_OVERFLOW;
                            state_next = S_DONE;
                        end
                        else if (count_reg >= CNT_W'(REGIONS))
                        begin
                            st_next    = ST_RANGE;
                            state_next = S_DONE;
                        end
                    end
                    CMD_VALIDATE:
                    begin
                        if (len_reg == '0)
                        begin
                            st_next    = ST_INVALID;
                            state_next = S_DONE;
                        end
                    end
                    CMD_READ:
                    begin
                        acc_len_next = 64'd1 << size_reg;
                        need_next    = PERM_READ;
                    end
                    CMD_WRITE:
                    begin
                        acc_len_next = 64'd1 << size_reg;
                        need_next    = PERM_WRITE;
                    end
                    CMD_FETCH:
                    begin
                        acc_len_next = FETCH_BYTES;
                        need_next    = PERM_EXEC;
                        if ((addr_reg & (FETCH_BYTES - 64'd1)) != '0)
                        begin
                            st_next    = ST_FAULT;
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        st_next    = ST_INVALID;
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (iss_reg < count_reg)
                begin
                    re          = 1'b1;
                    iss_next    = iss_reg + 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[IDX_W-1:0];
                end
                if (mres.valid && mres.hit)
                begin
                    flush       = 1'b1;
                    rd_vld_next = 1'b0;
                    state_next  = S_DONE;
                    if (is_map)
                    begin
                        st_next = ST_RANGE;
                    end
                    else
                    begin
                        st_next      = ST_OK;
                        res_idx_next = mres.idx;
                        res_off_next = mres.offset;
                    end
                end
                else if (iss_reg == count_reg && !rd_vld_reg)
                begin
                    flush       = 1'b1;
                    rd_vld_next = 1'b0;
                    state_next  = S_DONE;
                    if (is_map)
                    begin
                        st_next      = ST_OK;
                        res_idx_next = count_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        st_next = ST_FAULT;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_vld_next = 1'b1;
                    out_st_next  = st_reg;
                    out_idx_next = (st_reg == ST_OK) ? RIDX_W'(res_idx_reg) : '0;
                    out_off_next = (st_reg == ST_OK) ? res_off_reg : '0;
                    if (is_map && st_reg == ST_OK)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            iss_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            iss_reg     <= iss_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        addr_reg    <= addr_next;
        len_reg     <= len_next;
        size_reg    <= size_next;
        perms_reg   <= perms_next;
        acc_len_reg <= acc_len_next;
        need_reg    <= need_next;
        rd_idx_reg  <= rd_idx_next;
        st_reg      <= st_next;
        res_idx_reg <= res_idx_next;
        res_off_reg <= res_off_next;
        out_st_reg  <= out_st_next;
        out_idx_reg <= out_idx_next;
        out_off_reg <= out_off_next;
    end

endmodule
